[rtl/spq_pkg.sv]
// Shared types and codes for the sorted array priority queue.
// Used by spq_cell and by the top level; depends on nothing else.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int KEY_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int OIDX_W   = 4;
    localparam int OCNT_W   = 5;
    localparam int CAP_W    = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // What one cell hands to its right neighbor.
    typedef struct packed {
        logic                    valid;
        logic                    ge;
        logic signed [KEY_W-1:0] key;
    } t_link;

    // Broadcast command for the current transaction.
    typedef struct packed {
        logic                    insert;
        logic                    dequeue;
        logic signed [KEY_W-1:0] key;
    } t_ctrl;

endpackage

[rtl/spq_cell.sv]
// One slot of the sorted array: holds a key and its valid bit.
// Compares against the broadcast key and shifts with its left neighbor; uses spq_pkg.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_link i_left,
    input  logic  i_right_valid,
    output t_link o_link,
    output logic  o_last,
    output logic  o_match
);

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic                    n_valid;
    logic signed [KEY_W-1:0] n_key;
    logic                    w_ge;
    logic                    w_end;

    // Valid cells form a prefix, so the held keys at or above the search key
    // form a contiguous run ending at the last valid cell.
    assign w_ge   = r_valid && !(r_key < i_ctrl.key);
    assign w_end  = i_left.valid && !r_valid;
    assign o_last = r_valid && !i_right_valid;
    // The first cell of the run is the only place an equal key can be first.
    assign o_match = w_ge && !i_left.ge && (r_key == i_ctrl.key);

    assign o_link = '{valid: r_valid, ge: w_ge, key: r_key};

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        if (i_ctrl.insert) begin
            if (i_left.ge) begin
                n_valid = 1'b1;
                n_key   = i_left.key;
            end else if (w_ge || w_end) begin
                n_valid = 1'b1;
                n_key   = i_ctrl.key;
            end
        end else if (i_ctrl.dequeue && o_last) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
    end

endmodule

[rtl/sorted_array_priority_queue.sv]
// Sorted array priority queue built as a row of DEPTH compare-and-shift cells.
// The result is registered and appears in the cycle after the input transaction is accepted.
// Throughput: one transaction per cycle while the output is not stalled; every cell compares and shifts in that cycle.
// Reset clears the count and all cell valid bits and sets capacity to 16.
// Key storage is not reset; only cells marked valid are ever read.
`timescale 1ns / 1ps

module sorted_array_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CAP_W-1:0]      i_cfg_data,    // capacity
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [KEY_W-1:0]      s_axis_tdata,  // [31:0] key
    input  logic [OP_W-1:0]       s_axis_tuser,  // [1:0] op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,  // [31:0] out_key, [35:32] out_index,
                                                 // [40:36] count, [47:41] zero
    output logic [STATUS_W-1:0]   m_axis_tuser   // [1:0] status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0]        r_cap;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_status;
    logic [KEY_W-1:0]        r_out_key;
    logic [OIDX_W-1:0]       r_out_index;
    logic [OCNT_W-1:0]       r_out_count;

    logic                    w_accept;
    logic [LW-1:0]           w_limit;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_is_ins;
    logic                    w_is_deq;
    logic                    w_is_find;
    t_ctrl                   w_ctrl;
    t_link                   w_link [DEPTH+1];
    logic [DEPTH-1:0]        w_valid;
    logic [DEPTH:0]          w_rvalid;
    logic [DEPTH-1:0]        w_last;
    logic [DEPTH-1:0]        w_match;
    logic signed [KEY_W-1:0] w_deq_key;
    logic [IW-1:0]           w_find_idx;
    logic                    w_find_hit;
    logic [31:0]             w_idx_ext;
    logic [31:0]             w_cnt_ext;
    logic [STATUS_W-1:0]     w_status;
    logic [KEY_W-1:0]        w_okey;
    logic [IW-1:0]           w_oidx;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_limit = (LW'(r_cap) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(r_cap);
    assign w_full  = LW'(r_count) >= w_limit;
    assign w_empty = (r_count == '0);

    assign w_is_ins  = (s_axis_tuser == OP_INSERT);
    assign w_is_deq  = (s_axis_tuser == OP_DEQUEUE);
    assign w_is_find = (s_axis_tuser == OP_FIND);

    assign w_ctrl = '{insert:  w_accept && w_is_ins && !w_full,
                      dequeue: w_accept && w_is_deq && !w_empty,
                      key:     s_axis_tdata};

    // The virtual cell left of slot 0 is valid and never at or above the key.
    assign w_link[0] = '{valid: 1'b1, ge: 1'b0, key: '0};
    assign w_rvalid  = {1'b0, w_valid};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left        (w_link[g]),
            .i_right_valid (w_rvalid[g+1]),
            .o_link        (w_link[g+1]),
            .o_last        (w_last[g]),
            .o_match       (w_match[g])
        );
        assign w_valid[g] = w_link[g+1].valid;
    end

    // At most one cell raises last and at most one raises match, so these are
    // plain one-hot selections.
    always_comb begin
        w_deq_key  = '0;
        w_find_idx = '0;
        w_find_hit = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_last[i]) begin
                w_deq_key = w_deq_key | w_link[i+1].key;
            end
            if (w_match[i]) begin
                w_find_idx = w_find_idx | IW'(i);
                w_find_hit = 1'b1;
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        w_status = ST_OK;
        w_okey   = '0;
        w_oidx   = '0;
        if (w_is_ins) begin
            if (w_full) begin
                w_status = ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (w_is_deq) begin
            if (w_empty) begin
                w_status = ST_EMPTY;
            end else begin
                n_count = r_count - CW'(1);
                w_okey  = w_deq_key;
            end
        end else if (w_is_find) begin
            if (w_find_hit) begin
                w_oidx = w_find_idx;
            end else begin
                w_status = ST_NOT_FOUND;
            end
        end
    end

    assign w_idx_ext = 32'(w_oidx);
    assign w_cnt_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_status    <= w_status;
            r_out_key   <= w_okey;
            r_out_index <= w_idx_ext[OIDX_W-1:0];
            r_out_count <= w_cnt_ext[OCNT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {7'd0, r_out_count, r_out_index, r_out_key};

    // The valid bits in the row always agree with the count register.
    a_valid_matches_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count)
    ) else $error("cell valid bits disagree with count");

    // Valid cells always form a prefix of the row.
    a_valid_prefix: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid & (w_valid + DEPTH'(1))) == '0)
    ) else $error("valid cells are not a prefix");

    // An accepted insert with room grows the count by one.
    a_insert_grows: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_ins && !w_full) |=> (r_count == $past(r_count) + CW'(1))
    ) else $error("insert did not grow the count");

    // An empty report on dequeue always comes with a zero count.
    a_empty_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_EMPTY)) |-> (r_out_count == '0)
    ) else $error("empty status with nonzero count");

endmodule
